// ===== rtl/core/qalu_pkg.sv =====
// qalu_pkg: shared types, widths, opcodes and product index tables for the
// quaternion ALU. Used by qalu_div and quaternion_alu; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package qalu_pkg;

    localparam int FRAC_BITS = 27;
    localparam int DW        = 32;                          // component width
    localparam int QBITS     = 32;                          // quotient bits per divide
    localparam int DEN_W     = 65;                          // sum of four squares
    localparam int NUM_W     = DW + 2 * FRAC_BITS;          // widest dividend magnitude
    localparam int HI_W      = NUM_W - QBITS;
    localparam int CMP_W     = (HI_W > DEN_W) ? HI_W : DEN_W;
    localparam int ACC_W     = 67;                          // four-term product sum
    localparam int DIV_LAT   = QBITS + 3;                   // setup, steps, round, saturate
    localparam int PIPE_LAT  = DIV_LAT + 5;

    localparam logic [DW-1:0] WORD_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] WORD_MIN = {1'b1, {(DW-1){1'b0}}};

    typedef enum logic [3:0] {
        OP_MUL       = 4'd0,
        OP_DIV       = 4'd1,
        OP_ADD       = 4'd2,
        OP_SUB       = 4'd3,
        OP_ADDSCAL   = 4'd4,
        OP_SUBSCAL   = 4'd5,
        OP_SCALMINUS = 4'd6,
        OP_SCALE     = 4'd7,
        OP_DIVSCAL   = 4'd8,
        OP_CONJ      = 4'd9,
        OP_INV       = 4'd10,
        OP_DET       = 4'd11,
        OP_TRACE     = 4'd12
    } op_t;

    typedef logic [DW-1:0]  word_t;
    typedef word_t [3:0]    quat_t;

    typedef struct packed {
        op_t   op;
        quat_t a;
        quat_t b;
        word_t s;
    } item_t;

    // request state carried alongside the divider
    typedef struct packed {
        item_t            it;
        logic             detz;
        logic [DEN_W-1:0] det;
    } carry_t;

    // quaternion product: row k, term t uses a[IA] * b[IB], negated where SGN
    localparam logic [1:0] IA [4][4] = '{'{2'd0, 2'd1, 2'd2, 2'd3},
                                         '{2'd1, 2'd0, 2'd2, 2'd3},
                                         '{2'd2, 2'd1, 2'd0, 2'd3},
                                         '{2'd3, 2'd1, 2'd2, 2'd0}};
    localparam logic [1:0] IB [4][4] = '{'{2'd0, 2'd1, 2'd2, 2'd3},
                                         '{2'd0, 2'd1, 2'd3, 2'd2},
                                         '{2'd0, 2'd3, 2'd2, 2'd1},
                                         '{2'd0, 2'd2, 2'd1, 2'd3}};
    localparam logic SGN [4][4] = '{'{1'b0, 1'b1, 1'b1, 1'b1},
                                    '{1'b0, 1'b0, 1'b1, 1'b0},
                                    '{1'b0, 1'b0, 1'b0, 1'b1},
                                    '{1'b0, 1'b1, 1'b0, 1'b0}};

    // saturate a one-bit-grown value: returns {overflow, word}
    function automatic logic [DW:0] sat33(input logic [DW:0] v);
        logic ov;
        ov = v[DW] ^ v[DW-1];
        if (ov)
            return {1'b1, (v[DW] ? WORD_MIN : WORD_MAX)};
        return {1'b0, v[DW-1:0]};
    endfunction

    // saturated value of a divide by zero, by sign of the dividend
    function automatic word_t zd_val(input logic neg);
        return neg ? WORD_MIN : WORD_MAX;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/qalu_div.sv =====
// qalu_div: four-lane pipelined restoring divider, one quotient bit per stage,
// rounded to nearest (ties away) and saturated to 32 bits. Uses qalu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qalu_div (
    input  wire logic                          clk,
    input  wire logic [3:0][qalu_pkg::DW:0]    dividend,
    input  wire logic                          wide_shift,
    input  wire logic [qalu_pkg::DEN_W-1:0]    den,
    input  wire logic                          den_neg,
    output qalu_pkg::quat_t                    quo,
    output logic [3:0]                         quo_ov
);

    localparam int DW    = qalu_pkg::DW;
    localparam int QB    = qalu_pkg::QBITS;
    localparam int DEN_W = qalu_pkg::DEN_W;
    localparam int NUM_W = qalu_pkg::NUM_W;
    localparam int CMP_W = qalu_pkg::CMP_W;
    localparam int FB    = qalu_pkg::FRAC_BITS;

    logic [DEN_W-1:0] rem_reg  [0:QB][4];
    logic [QB-1:0]    nlo_reg  [0:QB][4];
    logic [QB-1:0]    q_reg    [0:QB][4];
    logic             pov_reg  [0:QB][4];
    logic             qneg_reg [0:QB][4];
    logic [DEN_W-1:0] d_reg    [0:QB];

    logic [DW:0]      qm_reg   [4];
    logic             pov2_reg [4];
    logic             qneg2_reg[4];
    qalu_pkg::quat_t  quo_reg;
    logic [3:0]       ov_reg;

    // setup: magnitudes, early overflow when the quotient needs more than 32 bits
    genvar k, j;
    generate
        for (k = 0; k < 4; k++) begin : g_setup
            logic             nneg;
            logic [DW:0]      mag;
            logic [NUM_W-1:0] num;
            logic [CMP_W-1:0] hi;
            always_comb
            begin
                nneg = dividend[k][DW];
                mag  = nneg ? (~dividend[k] + 1'b1) : dividend[k];
                num  = wide_shift ? (NUM_W'(mag[DW-1:0]) << (2 * FB))
                                  : (NUM_W'(mag[DW-1:0]) << FB);
                hi   = CMP_W'(num >> QB);
            end
            always_ff @(posedge clk)
            begin
                rem_reg[0][k]  <= hi[DEN_W-1:0];
                nlo_reg[0][k]  <= num[QB-1:0];
                q_reg[0][k]    <= '0;
                pov_reg[0][k]  <= hi >= CMP_W'(den);
                qneg_reg[0][k] <= nneg ^ den_neg;
            end
        end

        always_ff @(posedge clk)
        begin
            d_reg[0] <= den;
        end

        for (j = 0; j < QB; j++) begin : g_step
            always_ff @(posedge clk)
            begin
                d_reg[j+1] <= d_reg[j];
            end
            for (k = 0; k < 4; k++) begin : g_lane
                logic [DEN_W:0] rsh;
                logic [DEN_W:0] diff;
                logic           ge;
                always_comb
                begin
                    rsh  = {rem_reg[j][k], nlo_reg[j][k][QB-1]};
                    diff = rsh - {1'b0, d_reg[j]};
                    ge   = rsh >= {1'b0, d_reg[j]};
                end
                always_ff @(posedge clk)
                begin
                    rem_reg[j+1][k]  <= ge ? diff[DEN_W-1:0] : rsh[DEN_W-1:0];
                    nlo_reg[j+1][k]  <= {nlo_reg[j][k][QB-2:0], 1'b0};
                    q_reg[j+1][k]    <= {q_reg[j][k][QB-2:0], ge};
                    pov_reg[j+1][k]  <= pov_reg[j][k];
                    qneg_reg[j+1][k] <= qneg_reg[j][k];
                end
            end
        end

        for (k = 0; k < 4; k++) begin : g_fin
            logic       rnd;
            logic       ovf;
            logic [DW-1:0] mag;
            always_comb
            begin
                // round up when twice the remainder reaches the divisor
                rnd = {rem_reg[QB][k], 1'b0} >= {1'b0, d_reg[QB]};
                ovf = pov2_reg[k] | qm_reg[k][DW] |
                      (qneg2_reg[k] ? (qm_reg[k][DW-1] & (|qm_reg[k][DW-2:0]))
                                    : qm_reg[k][DW-1]);
                mag = qm_reg[k][DW-1:0];
            end
            always_ff @(posedge clk)
            begin
                qm_reg[k]    <= {1'b0, q_reg[QB][k]} + (DW+1)'(rnd);
                pov2_reg[k]  <= pov_reg[QB][k];
                qneg2_reg[k] <= qneg_reg[QB][k];
                if (ovf)
                    quo_reg[k] <= qalu_pkg::zd_val(qneg2_reg[k]);
                else
                    quo_reg[k] <= qneg2_reg[k] ? (~mag + 1'b1) : mag;
                ov_reg[k]    <= ovf;
            end
        end
    endgenerate

    assign quo    = quo_reg;
    assign quo_ov = ov_reg;

endmodule

`default_nettype wire

// ===== rtl/core/quaternion_alu.sv =====
// quaternion_alu: pipelined quaternion arithmetic unit, Q4.27 fixed point.
// Uses qalu_pkg and qalu_div.
//
//  channel   handshake        payload
//  request   start / busy     action, a0..a3, b0..b3, scalar_operand
//  result    done (strobe)    r0..r3, overflow, zero_divisor
//
// One request per cycle; each result appears in the order of its request.
// Every request passes through the 32-stage quotient pipeline (one bit per
// stage), plus squares, product and rounding stages. busy is never raised:
// nothing stalls. Reset clears the valid bits only.
`timescale 1ns / 1ps
`default_nettype none

module quaternion_alu (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [3:0]  action,
    input  wire logic [31:0] a0,
    input  wire logic [31:0] a1,
    input  wire logic [31:0] a2,
    input  wire logic [31:0] a3,
    input  wire logic [31:0] b0,
    input  wire logic [31:0] b1,
    input  wire logic [31:0] b2,
    input  wire logic [31:0] b3,
    input  wire logic [31:0] scalar_operand,
    output logic             done,
    output logic [31:0]      r0,
    output logic [31:0]      r1,
    output logic [31:0]      r2,
    output logic [31:0]      r3,
    output logic             overflow,
    output logic             zero_divisor
);

    localparam int DW    = qalu_pkg::DW;
    localparam int DEN_W = qalu_pkg::DEN_W;
    localparam int ACC_W = qalu_pkg::ACC_W;
    localparam int FB    = qalu_pkg::FRAC_BITS;
    localparam int DL    = qalu_pkg::DIV_LAT;
    localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (FB - 1);

    // ---------------- stage 1: squares of the divisor quaternion
    qalu_pkg::item_t  in_item;
    qalu_pkg::quat_t  sqx;
    logic             v1_reg;
    qalu_pkg::item_t  it1_reg;
    logic [63:0]      sq1_reg [4];

    always_comb
    begin
        in_item.op = qalu_pkg::op_t'(action);
        in_item.a  = {a3, a2, a1, a0};
        in_item.b  = {b3, b2, b1, b0};
        in_item.s  = scalar_operand;
        sqx = (action == qalu_pkg::OP_DIV) ? in_item.b : in_item.a;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        it1_reg <= in_item;
        for (int k = 0; k < 4; k++)
            sq1_reg[k] <= 64'($signed(sqx[k]) * $signed(sqx[k]));
    end

    // ---------------- stage 2: sum of squares
    logic             v2_reg;
    qalu_pkg::item_t  it2_reg;
    logic [DEN_W-1:0] det2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        it2_reg  <= it1_reg;
        det2_reg <= DEN_W'(sq1_reg[0]) + DEN_W'(sq1_reg[1])
                  + DEN_W'(sq1_reg[2]) + DEN_W'(sq1_reg[3]);
    end

    // ---------------- divider operands
    logic [3:0][DW:0]  dvd;
    logic              is_ds;
    qalu_pkg::quat_t   dx;
    logic [DW:0]       s33;
    logic [DW:0]       smag;
    logic [DEN_W-1:0]  dden;
    logic              dneg;

    always_comb
    begin
        is_ds = it2_reg.op == qalu_pkg::OP_DIVSCAL;
        dx    = (it2_reg.op == qalu_pkg::OP_DIV) ? it2_reg.b : it2_reg.a;
        for (int k = 0; k < 4; k++)
        begin
            if (is_ds)
                dvd[k] = {it2_reg.a[k][DW-1], it2_reg.a[k]};
            else if (k == 0)
                dvd[k] = {dx[k][DW-1], dx[k]};
            else
                dvd[k] = ~{dx[k][DW-1], dx[k]} + 1'b1;
        end
        s33  = {it2_reg.s[DW-1], it2_reg.s};
        smag = s33[DW] ? (~s33 + 1'b1) : s33;
        dden = is_ds ? DEN_W'(smag[DW-1:0]) : det2_reg;
        dneg = is_ds & it2_reg.s[DW-1];
    end

    qalu_pkg::quat_t quo;
    logic [3:0]      quo_ov;

    qalu_div u_div (
        .clk        (clk),
        .dividend   (dvd),
        .wide_shift (!is_ds),
        .den        (dden),
        .den_neg    (dneg),
        .quo        (quo),
        .quo_ov     (quo_ov)
    );

    // request state travels beside the divider
    logic              vl_reg [0:DL-1];
    qalu_pkg::carry_t  cl_reg [0:DL-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DL; i++)
                vl_reg[i] <= 1'b0;
        end
        else
        begin
            vl_reg[0] <= v2_reg;
            for (int i = 1; i < DL; i++)
                vl_reg[i] <= vl_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        cl_reg[0] <= '{it: it2_reg, detz: (det2_reg == '0), det: det2_reg};
        for (int i = 1; i < DL; i++)
            cl_reg[i] <= cl_reg[i-1];
    end

    // ---------------- stage M: sixteen products
    qalu_pkg::carry_t  cx;
    logic [DW-1:0]     ma [4][4];
    logic [DW-1:0]     mb [4][4];
    logic              vm_reg;
    qalu_pkg::carry_t  cm_reg;
    qalu_pkg::quat_t   invm_reg;
    logic [3:0]        dovm_reg;
    logic signed [63:0] pm_reg [4][4];

    always_comb
    begin
        cx = cl_reg[DL-1];
        for (int k = 0; k < 4; k++)
        begin
            for (int t = 0; t < 4; t++)
            begin
                unique case (cx.it.op)
                    qalu_pkg::OP_MUL:
                    begin
                        ma[k][t] = cx.it.a[qalu_pkg::IA[k][t]];
                        mb[k][t] = cx.it.b[qalu_pkg::IB[k][t]];
                    end
                    qalu_pkg::OP_DIV:
                    begin
                        ma[k][t] = cx.it.a[qalu_pkg::IA[k][t]];
                        mb[k][t] = quo[qalu_pkg::IB[k][t]];
                    end
                    qalu_pkg::OP_SCALE:
                    begin
                        ma[k][t] = (t == 0) ? cx.it.a[k] : '0;
                        mb[k][t] = (t == 0) ? cx.it.s : '0;
                    end
                    default:
                    begin
                        ma[k][t] = '0;
                        mb[k][t] = '0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vm_reg <= 1'b0;
        else
            vm_reg <= vl_reg[DL-1];
    end

    always_ff @(posedge clk)
    begin
        cm_reg   <= cx;
        invm_reg <= quo;
        dovm_reg <= quo_ov;
        for (int k = 0; k < 4; k++)
            for (int t = 0; t < 4; t++)
                pm_reg[k][t] <= $signed(ma[k][t]) * $signed(mb[k][t]);
    end

    // ---------------- stage S: exact row sums plus rounding half
    logic               vs_reg;
    qalu_pkg::carry_t   cs_reg;
    qalu_pkg::quat_t    invs_reg;
    logic [3:0]         dovs_reg;
    logic [ACC_W-1:0]   acc_reg [4];
    logic [ACC_W-1:0]   acc_nx  [4];

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            acc_nx[k] = HALF;
            for (int t = 0; t < 4; t++)
            begin
                if (qalu_pkg::SGN[k][t])
                    acc_nx[k] = acc_nx[k] - ACC_W'(pm_reg[k][t]);
                else
                    acc_nx[k] = acc_nx[k] + ACC_W'(pm_reg[k][t]);
            end
        end
        if (cm_reg.it.op == qalu_pkg::OP_DET)
            acc_nx[0] = ACC_W'(cm_reg.det) + HALF;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vs_reg <= 1'b0;
        else
            vs_reg <= vm_reg;
    end

    always_ff @(posedge clk)
    begin
        cs_reg   <= cm_reg;
        invs_reg <= invm_reg;
        dovs_reg <= dovm_reg;
        for (int k = 0; k < 4; k++)
            acc_reg[k] <= acc_nx[k];
    end

    // ---------------- final stage: scale down, saturate, select
    logic [ACC_W-1:0]  shv   [4];
    qalu_pkg::quat_t   row;
    logic [3:0]        row_ov;
    qalu_pkg::quat_t   res;
    logic              res_ov;
    logic              res_zd;
    logic [DW:0]       t33;
    qalu_pkg::item_t   fi;

    always_comb
    begin
        fi = cs_reg.it;
        for (int k = 0; k < 4; k++)
        begin
            shv[k]    = $signed(acc_reg[k]) >>> FB;
            row_ov[k] = !((shv[k][ACC_W-1:DW-1] == '0) || (&shv[k][ACC_W-1:DW-1]));
            row[k]    = row_ov[k] ? qalu_pkg::zd_val(shv[k][ACC_W-1]) : shv[k][DW-1:0];
        end
        res    = '0;
        res_ov = 1'b0;
        res_zd = 1'b0;
        t33    = '0;
        unique case (fi.op)
            qalu_pkg::OP_MUL, qalu_pkg::OP_SCALE:
            begin
                res    = row;
                res_ov = |row_ov;
            end
            qalu_pkg::OP_DIV:
            begin
                if (cs_reg.detz)
                begin
                    res_zd = 1'b1;
                    for (int k = 0; k < 4; k++)
                        res[k] = qalu_pkg::zd_val(fi.a[k][DW-1]);
                end
                else
                begin
                    res    = row;
                    res_ov = (|row_ov) | (|dovs_reg);
                end
            end
            qalu_pkg::OP_INV:
            begin
                if (cs_reg.detz)
                begin
                    res_zd = 1'b1;
                    res[0] = qalu_pkg::zd_val(fi.a[0][DW-1]);
                    for (int k = 1; k < 4; k++)
                        res[k] = qalu_pkg::zd_val(!fi.a[k][DW-1] && (fi.a[k] != '0));
                end
                else
                begin
                    res    = invs_reg;
                    res_ov = |dovs_reg;
                end
            end
            qalu_pkg::OP_DIVSCAL:
            begin
                if (fi.s == '0)
                begin
                    res_zd = 1'b1;
                    for (int k = 0; k < 4; k++)
                        res[k] = qalu_pkg::zd_val(fi.a[k][DW-1]);
                end
                else
                begin
                    res    = invs_reg;
                    res_ov = |dovs_reg;
                end
            end
            qalu_pkg::OP_ADD, qalu_pkg::OP_SUB, qalu_pkg::OP_ADDSCAL,
            qalu_pkg::OP_SUBSCAL, qalu_pkg::OP_SCALMINUS:
            begin
                for (int k = 0; k < 4; k++)
                begin
                    unique case (fi.op)
                        qalu_pkg::OP_ADD:
                            t33 = {fi.a[k][DW-1], fi.a[k]} + {fi.b[k][DW-1], fi.b[k]};
                        qalu_pkg::OP_SUB:
                            t33 = {fi.a[k][DW-1], fi.a[k]} - {fi.b[k][DW-1], fi.b[k]};
                        qalu_pkg::OP_ADDSCAL:
                            t33 = {fi.a[k][DW-1], fi.a[k]} + {fi.s[DW-1], fi.s};
                        qalu_pkg::OP_SUBSCAL:
                            t33 = {fi.a[k][DW-1], fi.a[k]} - {fi.s[DW-1], fi.s};
                        default:
                            t33 = {fi.s[DW-1], fi.s} - {fi.a[k][DW-1], fi.a[k]};
                    endcase
                    t33    = qalu_pkg::sat33(t33);
                    res[k] = t33[DW-1:0];
                    res_ov = res_ov | t33[DW];
                end
            end
            qalu_pkg::OP_CONJ:
            begin
                res[0] = fi.a[0];
                for (int k = 1; k < 4; k++)
                begin
                    t33    = qalu_pkg::sat33(~{fi.a[k][DW-1], fi.a[k]} + 1'b1);
                    res[k] = t33[DW-1:0];
                    res_ov = res_ov | t33[DW];
                end
            end
            qalu_pkg::OP_DET:
            begin
                res[0] = row[0];
                res_ov = row_ov[0];
            end
            qalu_pkg::OP_TRACE:
            begin
                t33    = qalu_pkg::sat33({fi.a[0], 1'b0});
                res[0] = t33[DW-1:0];
                res_ov = t33[DW];
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

    logic            done_reg;
    qalu_pkg::quat_t res_reg;
    logic            ov_reg;
    logic            zd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= vs_reg;
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res;
        ov_reg  <= res_ov;
        zd_reg  <= res_zd;
    end

    assign busy         = 1'b0;
    assign done         = done_reg;
    assign r0           = res_reg[0];
    assign r1           = res_reg[1];
    assign r2           = res_reg[2];
    assign r3           = res_reg[3];
    assign overflow     = ov_reg;
    assign zero_divisor = zd_reg;

    // ---------------- checks
    a_done_has_request: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, qalu_pkg::PIPE_LAT))
        else $error("result without a matching request");

    a_request_gets_result: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##(qalu_pkg::PIPE_LAT) done)
        else $error("request lost in pipeline");

    a_zd_excludes_ov: assert property (@(posedge clk) disable iff (!rst_n)
        done && zero_divisor |-> !overflow)
        else $error("zero divisor reported with overflow");

    a_scalar_result: assert property (@(posedge clk) disable iff (!rst_n)
        done && ($past(action, qalu_pkg::PIPE_LAT) == qalu_pkg::OP_DET ||
                 $past(action, qalu_pkg::PIPE_LAT) == qalu_pkg::OP_TRACE)
        |-> (r1 == '0 && r2 == '0 && r3 == '0))
        else $error("scalar result with nonzero vector part");

endmodule

`default_nettype wire

// ===== bench/quaternion_alu_test.sv =====
// quaternion_alu_test: self-checking bench for the quaternion ALU.
// Depends on qalu_pkg and quaternion_alu; predicts each result in wide integer math.
`timescale 1ns / 1ps

module quaternion_alu_test;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic [3:0]       action;
        qalu_pkg::quat_t  a;
        qalu_pkg::quat_t  b;
        qalu_pkg::word_t  s;
    } request_t;

    typedef struct {
        qalu_pkg::word_t r [4];
        logic            ov;
        logic            zd;
    } answer_t;

    localparam wide_t W_MAX = 128'sd2147483647;
    localparam wide_t W_MIN = -128'sd2147483648;

    // opcodes with no operation behind them
    localparam logic [3:0] ACT_UNDEF_LO = 4'(qalu_pkg::OP_TRACE) + 4'd1;
    localparam logic [3:0] ACT_UNDEF_HI = 4'hF;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [3:0]  action;
    logic [31:0] a0, a1, a2, a3, b0, b1, b2, b3, scalar_operand;
    logic        done;
    logic [31:0] r0, r1, r2, r3;
    logic        overflow, zero_divisor;

    request_t pending_requests [$];
    answer_t  expected_answers [$];
    request_t cur;
    int       gap_left;
    int       mismatches;
    bit       failed;

    quaternion_alu DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .action(action),
        .a0(a0), .a1(a1), .a2(a2), .a3(a3), .b0(b0), .b1(b1), .b2(b2), .b3(b3),
        .scalar_operand(scalar_operand), .done(done), .r0(r0), .r1(r1), .r2(r2),
        .r3(r3), .overflow(overflow), .zero_divisor(zero_divisor)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic wide_t widen(input qalu_pkg::word_t w);
        return wide_t'($signed(w));
    endfunction

    function automatic qalu_pkg::word_t clip(input wide_t x, inout logic ov);
        if (x > W_MAX)
        begin
            ov = 1'b1;
            return qalu_pkg::WORD_MAX;
        end
        if (x < W_MIN)
        begin
            ov = 1'b1;
            return qalu_pkg::WORD_MIN;
        end
        return x[31:0];
    endfunction

    // round half up, drop fraction bits
    function automatic qalu_pkg::word_t round_fix(input wide_t x, inout logic ov);
        wide_t y;
        y = (x + (wide_t'(1) <<< (qalu_pkg::FRAC_BITS - 1))) >>> qalu_pkg::FRAC_BITS;
        return clip(y, ov);
    endfunction

    // nearest, ties away from zero
    function automatic qalu_pkg::word_t quot_round(input wide_t num, input wide_t den,
                                                   inout logic ov);
        logic [127:0] n, d, q, rem;
        logic         neg;
        wide_t        res;
        neg = num[127] ^ den[127];
        n = num[127] ? -num : num;
        d = den[127] ? -den : den;
        q = n / d;
        rem = n % d;
        if (rem >= d - rem)
            q = q + 1;
        res = neg ? -$signed(q) : $signed(q);
        return clip(res, ov);
    endfunction

    function automatic void hamilton(input wide_t x [4], input wide_t y [4],
                                     output qalu_pkg::word_t r [4], inout logic ov);
        r[0] = round_fix(x[0]*y[0] - x[1]*y[1] - x[2]*y[2] - x[3]*y[3], ov);
        r[1] = round_fix(x[1]*y[0] + x[0]*y[1] - x[2]*y[3] + x[3]*y[2], ov);
        r[2] = round_fix(x[2]*y[0] + x[1]*y[3] + x[0]*y[2] - x[3]*y[1], ov);
        r[3] = round_fix(x[3]*y[0] - x[1]*y[2] + x[2]*y[1] + x[0]*y[3], ov);
    endfunction

    function automatic wide_t norm2(input wide_t x [4]);
        return x[0]*x[0] + x[1]*x[1] + x[2]*x[2] + x[3]*x[3];
    endfunction

    function automatic answer_t predict_answer(input request_t rq);
        answer_t         ans;
        wide_t           x [4], y [4], c [4], yi [4];
        qalu_pkg::word_t inv_w [4];
        wide_t           s, d;
        ans.ov = 1'b0;
        ans.zd = 1'b0;
        for (int k = 0; k < 4; k++)
        begin
            x[k] = widen(rq.a[k]);
            y[k] = widen(rq.b[k]);
            ans.r[k] = '0;
        end
        s = widen(rq.s);
        case (qalu_pkg::op_t'(rq.action))
            qalu_pkg::OP_MUL: hamilton(x, y, ans.r, ans.ov);
            qalu_pkg::OP_DIV, qalu_pkg::OP_INV:
            begin
                if (qalu_pkg::op_t'(rq.action) == qalu_pkg::OP_INV)
                    y = x;
                d = norm2(y);
                for (int k = 0; k < 4; k++)
                    c[k] = (k == 0) ? y[0] : -y[k];
                if (d == 0)
                begin
                    ans.zd = 1'b1;
                    for (int k = 0; k < 4; k++)
                        if (qalu_pkg::op_t'(rq.action) == qalu_pkg::OP_INV)
                            ans.r[k] = (c[k] < 0) ? qalu_pkg::WORD_MIN : qalu_pkg::WORD_MAX;
                        else
                            ans.r[k] = (x[k] < 0) ? qalu_pkg::WORD_MIN : qalu_pkg::WORD_MAX;
                end
                else
                begin
                    for (int k = 0; k < 4; k++)
                        inv_w[k] = quot_round(c[k] <<< (2 * qalu_pkg::FRAC_BITS), d, ans.ov);
                    if (qalu_pkg::op_t'(rq.action) == qalu_pkg::OP_INV)
                        ans.r = inv_w;
                    else
                    begin
                        for (int k = 0; k < 4; k++)
                            yi[k] = widen(inv_w[k]);
                        hamilton(x, yi, ans.r, ans.ov);
                    end
                end
            end
            qalu_pkg::OP_ADD:
                for (int k = 0; k < 4; k++) ans.r[k] = clip(x[k] + y[k], ans.ov);
            qalu_pkg::OP_SUB:
                for (int k = 0; k < 4; k++) ans.r[k] = clip(x[k] - y[k], ans.ov);
            qalu_pkg::OP_ADDSCAL:
                for (int k = 0; k < 4; k++) ans.r[k] = clip(x[k] + s, ans.ov);
            qalu_pkg::OP_SUBSCAL:
                for (int k = 0; k < 4; k++) ans.r[k] = clip(x[k] - s, ans.ov);
            qalu_pkg::OP_SCALMINUS:
                for (int k = 0; k < 4; k++) ans.r[k] = clip(s - x[k], ans.ov);
            qalu_pkg::OP_SCALE:
                for (int k = 0; k < 4; k++) ans.r[k] = round_fix(x[k] * s, ans.ov);
            qalu_pkg::OP_DIVSCAL:
            begin
                if (s == 0)
                begin
                    ans.zd = 1'b1;
                    for (int k = 0; k < 4; k++)
                        ans.r[k] = (x[k] < 0) ? qalu_pkg::WORD_MIN : qalu_pkg::WORD_MAX;
                end
                else
                    for (int k = 0; k < 4; k++)
                        ans.r[k] = quot_round(x[k] <<< qalu_pkg::FRAC_BITS, s, ans.ov);
            end
            qalu_pkg::OP_CONJ:
            begin
                ans.r[0] = rq.a[0];
                for (int k = 1; k < 4; k++) ans.r[k] = clip(-x[k], ans.ov);
            end
            qalu_pkg::OP_DET:   ans.r[0] = round_fix(norm2(x), ans.ov);
            qalu_pkg::OP_TRACE: ans.r[0] = clip(2 * x[0], ans.ov);
            default: ;
        endcase
        return ans;
    endfunction

    function automatic qalu_pkg::word_t pick_word();
        case ($urandom_range(0, 9))
            0, 1, 2: return $urandom;
            3, 4, 5: return qalu_pkg::word_t'($signed($urandom_range(0, 1 << 29)) - (1 << 28));
            6:
            begin
                case ($urandom_range(0, 6))
                    0: return qalu_pkg::WORD_MAX;
                    1: return qalu_pkg::WORD_MIN;
                    2: return 32'd1 << qalu_pkg::FRAC_BITS;
                    3: return -(32'd1 << qalu_pkg::FRAC_BITS);
                    4: return 32'd1;
                    5: return 32'hFFFF_FFFF;
                    default: return 32'd0;
                endcase
            end
            7: return qalu_pkg::word_t'($signed($urandom_range(0, 64)) - 32);
            default: return 32'd0;
        endcase
    endfunction

    task automatic add_request(input logic [3:0] act, input qalu_pkg::quat_t qa,
                               input qalu_pkg::quat_t qb, input qalu_pkg::word_t sc);
        request_t rq;
        rq.action = act;
        rq.a = qa;
        rq.b = qb;
        rq.s = sc;
        pending_requests.push_back(rq);
    endtask

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                expected_answers.push_back(predict_answer(cur));
            if (start && !busy || !start)
            begin
                if (gap_left > 0 || pending_requests.size() == 0)
                begin
                    if (gap_left > 0)
                        gap_left--;
                    start <= 1'b0;
                end
                else
                begin
                    cur = pending_requests.pop_front();
                    start <= 1'b1;
                    action <= cur.action;
                    a0 <= cur.a[0]; a1 <= cur.a[1]; a2 <= cur.a[2]; a3 <= cur.a[3];
                    b0 <= cur.b[0]; b1 <= cur.b[1]; b2 <= cur.b[2]; b3 <= cur.b[3];
                    scalar_operand <= cur.s;
                    if (pending_requests.size() > 200 && $urandom_range(0, 5) == 0)
                        gap_left = $urandom_range(1, 11);
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && done)
        begin
            if (expected_answers.size() == 0)
            begin
                failed = 1'b1;
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result r0=%h r1=%h r2=%h r3=%h", r0, r1, r2, r3);
            end
            else
            begin
                want = expected_answers.pop_front();
                if (r0 !== want.r[0] || r1 !== want.r[1] || r2 !== want.r[2] ||
                    r3 !== want.r[3] || overflow !== want.ov || zero_divisor !== want.zd)
                begin
                    failed = 1'b1;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: got %h %h %h %h ov=%b zd=%b, exp %h %h %h %h ov=%b zd=%b",
                                 r0, r1, r2, r3, overflow, zero_divisor,
                                 want.r[0], want.r[1], want.r[2], want.r[3], want.ov, want.zd);
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        qalu_pkg::quat_t zq, one, mx, mn, qa, qb;
        logic [3:0]      act;
        rst_n = 1'b0;
        start = 1'b0;
        action = '0;
        {a0, a1, a2, a3, b0, b1, b2, b3, scalar_operand} = '0;
        gap_left = 0;
        mismatches = 0;
        failed = 1'b0;
        zq = '0;
        one = '0;
        one[0] = 32'd1 << qalu_pkg::FRAC_BITS;
        mx = {qalu_pkg::WORD_MAX, qalu_pkg::WORD_MAX, qalu_pkg::WORD_MAX, qalu_pkg::WORD_MAX};
        mn = {qalu_pkg::WORD_MIN, qalu_pkg::WORD_MIN, qalu_pkg::WORD_MIN, qalu_pkg::WORD_MIN};

        // directed corners
        add_request(qalu_pkg::OP_MUL, mx, mx, '0);
        add_request(qalu_pkg::OP_MUL, mn, mx, '0);
        add_request(qalu_pkg::OP_MUL, one, one, '0);
        add_request(qalu_pkg::OP_DIV, mx, zq, '0);           // zero divisor, B is zero
        add_request(qalu_pkg::OP_DIV, mn, one, '0);
        add_request(qalu_pkg::OP_ADD, mx, mx, '0);
        add_request(qalu_pkg::OP_SUB, mn, mx, '0);
        add_request(qalu_pkg::OP_ADDSCAL, mx, zq, qalu_pkg::WORD_MAX);
        add_request(qalu_pkg::OP_SUBSCAL, mn, zq, qalu_pkg::WORD_MAX);
        add_request(qalu_pkg::OP_SCALMINUS, mn, zq, qalu_pkg::WORD_MAX);
        add_request(qalu_pkg::OP_SCALE, mx, zq, qalu_pkg::WORD_MIN);
        add_request(qalu_pkg::OP_DIVSCAL, {qalu_pkg::WORD_MIN, 32'd5, 32'd0, qalu_pkg::WORD_MAX},
                    zq, '0);
        add_request(qalu_pkg::OP_DIVSCAL, {32'd3, -32'd3, 32'd1, -32'd1}, zq,
                    32'd2 << qalu_pkg::FRAC_BITS);
        add_request(qalu_pkg::OP_CONJ, mn, zq, '0);          // negating the most negative value
        add_request(qalu_pkg::OP_INV, zq, zq, '0);
        add_request(qalu_pkg::OP_INV, {qalu_pkg::WORD_MIN, 32'd0, 32'd0, 32'd0}, zq, '0);
        add_request(qalu_pkg::OP_INV, one, zq, '0);
        add_request(qalu_pkg::OP_DET, mn, zq, '0);
        add_request(qalu_pkg::OP_TRACE, mx, zq, '0);
        add_request(qalu_pkg::OP_TRACE, mn, zq, '0);
        add_request(ACT_UNDEF_LO, mx, mx, qalu_pkg::WORD_MAX);
        add_request(ACT_UNDEF_LO + 4'd1, mn, mn, qalu_pkg::WORD_MIN);
        add_request(ACT_UNDEF_HI, mx, mn, qalu_pkg::WORD_MAX);

        for (int n = 0; n < 1250; n++)
        begin
            act = ($urandom_range(0, 40) == 0)
                ? 4'($urandom_range(ACT_UNDEF_LO, ACT_UNDEF_HI))
                : 4'($urandom_range(qalu_pkg::OP_MUL, qalu_pkg::OP_TRACE));
            for (int k = 0; k < 4; k++)
            begin
                qa[k] = pick_word();
                qb[k] = pick_word();
            end
            if ($urandom_range(0, 15) == 0)
                qb = zq;
            add_request(act, qa, qb, pick_word());
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        do @(posedge clk);
        while (pending_requests.size() != 0 || start || expected_answers.size() != 0);
        repeat (qalu_pkg::PIPE_LAT + 20) @(posedge clk);
        if (!failed)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
